FILE: rtl/assert_macros.svh
// assertion macros for the rtl, included by float_format_converter_top
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ffc_pkg.sv
// shared types, constants and conversion functions for the format converter
// no dependencies
`default_nettype none

package ffc_pkg;

    localparam int CmdWidth  = 2;
    localparam int DataWidth = 32;

    typedef enum logic [CmdWidth-1:0] {
        CMD_F32_TO_F16  = 2'd0,
        CMD_F16_TO_F32  = 2'd1,
        CMD_F32_TO_BF16 = 2'd2,
        CMD_BF16_TO_F32 = 2'd3
    } cmd_t;

    // binary32 to binary16, round to nearest even
    function automatic logic [15:0] to_half(input logic [31:0] bits);
        logic        sign;
        logic [7:0]  expo;
        logic [22:0] frac;
        logic [23:0] sig;
        logic [4:0]  sh;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] half;
        logic [23:0] mask;
        logic [10:0] m;
        logic [12:0] lrem;
        logic [15:0] res;
        sign = bits[31];
        expo = bits[30:23];
        frac = bits[22:0];
        sig  = {1'b1, frac};
        sh   = 5'd0;
        q    = '0;
        rem  = '0;
        half = '0;
        mask = '0;
        m    = '0;
        lrem = '0;
        if (expo == 8'hff) begin
            res = {sign, 5'h1f, (frac != 23'd0), 9'd0};
        end else if (expo >= 8'd143) begin
            res = {sign, 15'h7c00};
        end else if (expo <= 8'd112) begin
            if (expo < 8'd102) begin
                res = {sign, 15'd0};
            end else begin
                // shift of 14..24 for half subnormals
                sh   = 5'(8'd126 - expo);
                q    = sig >> sh;
                mask = (24'd1 << sh) - 24'd1;
                rem  = sig & mask;
                half = 24'd1 << (sh - 5'd1);
                if (rem > half || (rem == half && q[0]))
                    q = q + 24'd1;
                res = {sign, q[14:0]};
            end
        end else begin
            m    = {1'b0, frac[22:13]};
            lrem = frac[12:0];
            if (lrem > 13'h1000 || (lrem == 13'h1000 && m[0]))
                m = m + 11'd1;
            // mantissa carry rolls into the exponent, may reach infinity
            res = {sign, 15'({5'(expo - 8'd112), 10'd0} + {4'd0, m})};
        end
        return res;
    endfunction

    // binary16 to binary32, normalising subnormals
    function automatic logic [31:0] from_half(input logic [15:0] h);
        logic       sign;
        logic [4:0] expo;
        logic [9:0] m;
        logic [3:0] lz;
        logic [9:0] ms;
        logic [31:0] res;
        sign = h[15];
        expo = h[14:10];
        m    = h[9:0];
        lz   = 4'd0;
        for (int i = 9; i >= 0; i--) begin
            if (m[i] && lz == 4'd0 && (m >> i) == 10'd1)
                lz = 4'(10 - i);
        end
        ms = 10'(m << lz);
        if (expo == 5'd0) begin
            if (m == 10'd0)
                res = {sign, 31'd0};
            else
                res = {sign, 8'(8'd113 - {4'd0, lz}), ms, 13'd0};
        end else if (expo == 5'h1f) begin
            res = {sign, 8'hff, m, 13'd0};
        end else begin
            res = {sign, 8'({3'd0, expo} + 8'd112), m, 13'd0};
        end
        return res;
    endfunction

    // binary32 to bfloat16, bias wraps at 32 bits
    function automatic logic [15:0] to_bf16(input logic [31:0] bits);
        logic [31:0] sum;
        sum = bits + 32'h7fff + {31'd0, bits[16]};
        return sum[31:16];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ffc_core.sv
// combinational conversion datapath selected by command
// depends on ffc_pkg
`default_nettype none

module ffc_core (
    input  wire ffc_pkg::cmd_t   cmd,
    input  wire logic [31:0]     operand_bits,
    output logic [31:0]          result_bits
);

    always_comb
    begin
        unique case (cmd)
            ffc_pkg::CMD_F32_TO_F16:  result_bits = {16'd0, ffc_pkg::to_half(operand_bits)};
            ffc_pkg::CMD_F16_TO_F32:  result_bits = ffc_pkg::from_half(operand_bits[15:0]);
            ffc_pkg::CMD_F32_TO_BF16: result_bits = {16'd0, ffc_pkg::to_bf16(operand_bits)};
            ffc_pkg::CMD_BF16_TO_F32: result_bits = {operand_bits[15:0], 16'd0};
            default:                  result_bits = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/float_format_converter_top.sv
// float format converter: binary32 / binary16 / bfloat16 conversions
// input register, ffc_core datapath, result register with skid stage
// depends on ffc_pkg, ffc_core, assert_macros.svh
//
// usage:
//   input channel  in_valid/in_ready carries cmd and operand_bits
//   output channel out_valid/out_ready carries result_bits
//   one result per transfer, in order
//   items pass the input register, then the result register (via the
//   skid entry under a stall); no item is lost across a stall
//   throughput: one item per cycle while out_ready stays high, set by
//   the single-pass datapath between the input and result registers
//   in_ready is low only while the skid entry is full: a stall on
//   out_ready fills one skid entry, then in_ready drops until the
//   receiver takes a result; reset clears all valid flags
`default_nettype none
`include "assert_macros.svh"

module float_format_converter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] operand_bits,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      result_bits
);

    logic                 s1_valid_reg;
    ffc_pkg::cmd_t        s1_cmd_reg;
    logic [31:0]          s1_op_reg;
    logic [31:0]          conv;
    logic                 out_valid_reg;
    logic [31:0]          out_data_reg;
    logic                 skid_valid_reg;
    logic [31:0]          skid_data_reg;
    logic                 s1_adv;

    ffc_core u_core (
        .cmd          (s1_cmd_reg),
        .operand_bits (s1_op_reg),
        .result_bits  (conv)
    );

    assign in_ready    = !skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign result_bits = out_data_reg;
    // stage 1 result goes to output or skid whenever skid is empty
    assign s1_adv = s1_valid_reg && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_cmd_reg <= ffc_pkg::cmd_t'(cmd);
            s1_op_reg  <= operand_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg  <= skid_valid_reg || s1_adv;
                skid_valid_reg <= 1'b0;
            end
            else if (s1_adv)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (s1_adv)
                out_data_reg <= conv;
        end
        else if (s1_adv)
            skid_data_reg <= conv;
    end

    `ASSERT_CLK(a_skid_needs_out, clk, rst_n, !skid_valid_reg || out_valid_reg, "skid full with empty output")
    `ASSERT_IMP(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped under stall")
    `ASSERT_IMP(a_skid_blocks, clk, rst_n, skid_valid_reg && !out_ready, !in_ready, "input taken with full skid")

endmodule

`default_nettype wire

FILE: tb/sv/tb_float_format_converter_top.sv
// self-checking testbench for float_format_converter_top
// predicts each conversion in place and compares results in order; uses ffc_pkg
`default_nettype none

module tb_float_format_converter_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [31:0] operand_bits;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result_bits;

    typedef struct packed {
        ffc_pkg::cmd_t op;
        logic [31:0]   bits;
    } conv_item_t;

    conv_item_t  pending_q[$];
    logic [31:0] expected_q[$];
    int          mismatches;
    int          checked;
    int          sent;
    int          idle_cycles;
    int          send_gap;
    int          recv_gap;
    int          hold_off;
    bit          hold_req;

    float_format_converter_top uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .operand_bits(operand_bits), .out_valid(out_valid),
        .out_ready(out_ready), .result_bits(result_bits)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] narrow_to_half(input logic [31:0] b);
        logic [31:0] sgn;
        logic [31:0] ex;
        logic [31:0] fr;
        int          hexp;
        logic [31:0] sig;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] hlf;
        int          sh;
        sgn  = (b >> 16) & 32'h8000;
        ex   = (b >> 23) & 32'hff;
        fr   = b & 32'h7fffff;
        if (ex == 32'hff)
            return sgn | 32'h7c00 | (fr != 0 ? 32'h0200 : 32'h0);
        hexp = int'(ex) - 112;
        if (hexp >= 31)
            return sgn | 32'h7c00;
        if (hexp <= 0)
        begin
            if (hexp < -10)
                return sgn;
            sig = fr | 32'h800000;
            sh  = 14 - hexp;
            q   = sig >> sh;
            rem = sig & ((32'd1 << sh) - 1);
            hlf = 32'd1 << (sh - 1);
            if (rem > hlf || (rem == hlf && q[0]))
                q = q + 1;
            return sgn | q;
        end
        q   = fr >> 13;
        rem = fr & 32'h1fff;
        if (rem > 32'h1000 || (rem == 32'h1000 && q[0]))
        begin
            q = q + 1;
            if (q == 32'h400)
            begin
                if (hexp + 1 >= 31)
                    return sgn | 32'h7c00;
                return sgn | (32'(hexp + 1) << 10);
            end
        end
        return sgn | (32'(hexp) << 10) | q;
    endfunction

    function automatic logic [31:0] widen_from_half(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  ex;
        logic [10:0] m;
        int          lz;
        sgn = {h[15], 31'd0};
        ex  = h[14:10];
        m   = {1'b0, h[9:0]};
        lz  = 0;
        if (ex == 5'd0)
        begin
            if (m == 0)
                return sgn;
            while (!m[10] && lz < 10)
            begin
                m  = m << 1;
                lz = lz + 1;
            end
            return sgn | (32'(113 - lz) << 23) | (32'(m[9:0]) << 13);
        end
        if (ex == 5'h1f)
            return sgn | 32'h7f800000 | (32'(m) << 13);
        return sgn | ((32'(ex) + 112) << 23) | (32'(m) << 13);
    endfunction

    function automatic logic [31:0] converted_bits(input conv_item_t it);
        logic [31:0] s;
        case (it.op)
            ffc_pkg::CMD_F32_TO_F16:  return narrow_to_half(it.bits);
            ffc_pkg::CMD_F16_TO_F32:  return widen_from_half(it.bits[15:0]);
            ffc_pkg::CMD_F32_TO_BF16:
            begin
                s = it.bits + 32'h7fff + {31'd0, it.bits[16]};
                return {16'd0, s[31:16]};
            end
            default:                  return {it.bits[15:0], 16'd0};
        endcase
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) != 0)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(5, 30);
        return $urandom_range(1, 3);
    endfunction

    task automatic add_item(input ffc_pkg::cmd_t op, input logic [31:0] b);
        conv_item_t it;
        it.op   = op;
        it.bits = b;
        pending_q.push_back(it);
    endtask

    // random operand weighted towards the interesting exponent bands and rounding ties
    function automatic logic [31:0] rand_operand(input ffc_pkg::cmd_t op);
        logic [31:0] b;
        int          sel;
        b   = $urandom;
        sel = $urandom_range(0, 5);
        if (op == ffc_pkg::CMD_F32_TO_F16)
        begin
            case (sel)
                0: b[30:23] = 8'(32'($urandom_range(100, 114)));
                1: b[30:23] = 8'(32'($urandom_range(140, 145)));
                2: b[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                3: b[12:0]  = 13'h1000;
                default: ;
            endcase
        end
        else if (op == ffc_pkg::CMD_F16_TO_F32 && sel < 2)
            b[14:10] = sel == 0 ? 5'd0 : 5'h1f;
        else if (op == ffc_pkg::CMD_F32_TO_BF16 && sel == 0)
            b[15:0] = 16'h8000;
        return b;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            cmd          <= 2'd0;
            operand_bits <= '0;
            send_gap     <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(converted_bits(pending_q.pop_front()));
                sent = sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0 || pending_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap <= send_gap - 1;
                end
                else
                begin
                    in_valid     <= 1'b1;
                    cmd          <= pending_q[0].op;
                    operand_bits <= pending_q[0].bits;
                    send_gap     <= pick_gap();
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
            hold_off  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                checked = checked + 1;
                if (expected_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result %h", result_bits);
                end
                else if (expected_q[0] !== result_bits)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h actual %h",
                                 expected_q[0], result_bits);
                    void'(expected_q.pop_front());
                end
                else
                    void'(expected_q.pop_front());
            end
            if (hold_req && hold_off == 0)
            begin
                hold_off  <= 200;
                out_ready <= 1'b0;
            end
            else if (hold_off > 0)
            begin
                hold_off  <= hold_off - 1;
                out_ready <= hold_off == 1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                recv_gap  <= pick_gap();
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 2000)
        begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        ffc_pkg::cmd_t op;
        int            n;
        mismatches = 0;
        checked    = 0;
        sent       = 0;
        hold_req   = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_ready  = 1'b0;
        cmd        = 2'd0;
        operand_bits = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'h0000_0000);
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'hffff_ffff);
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'h7f80_0000);
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'h7fc0_0001);
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'h8000_0001);
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'h477f_f000);
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'h477f_efff);
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'h3380_0000);
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'h3380_0001);
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'h387f_e000);
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'h3f80_3000);
        add_item(ffc_pkg::CMD_F32_TO_F16, 32'h3300_0000);
        add_item(ffc_pkg::CMD_F16_TO_F32, 32'hffff_0001);
        add_item(ffc_pkg::CMD_F16_TO_F32, 32'h0000_83ff);
        add_item(ffc_pkg::CMD_F16_TO_F32, 32'h0000_7c00);
        add_item(ffc_pkg::CMD_F16_TO_F32, 32'h1234_7e55);
        add_item(ffc_pkg::CMD_F16_TO_F32, 32'h0000_8000);
        add_item(ffc_pkg::CMD_F32_TO_BF16, 32'h7fff_ffff);
        add_item(ffc_pkg::CMD_F32_TO_BF16, 32'hffff_8000);
        add_item(ffc_pkg::CMD_F32_TO_BF16, 32'h3f80_8000);
        add_item(ffc_pkg::CMD_F32_TO_BF16, 32'h3f81_8000);
        add_item(ffc_pkg::CMD_F32_TO_BF16, 32'h0000_0000);
        add_item(ffc_pkg::CMD_BF16_TO_F32, 32'habcd_ffff);
        add_item(ffc_pkg::CMD_BF16_TO_F32, 32'hffff_0000);
        for (n = 0; n < 400; n++)
        begin
            op = ffc_pkg::cmd_t'($urandom_range(0, 3));
            add_item(op, rand_operand(op));
        end

        // long receiver stall midway through
        wait (sent >= 150);
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;

        wait (pending_q.size() == 0 && !in_valid);
        wait (expected_q.size() == 0);
        repeat (20) @(posedge clk);
        $display("covered %0d conversions over all four commands", checked);
        $display("with random gaps and one long output stall");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/ffc_pkg.sv
rtl/ffc_core.sv
rtl/float_format_converter_top.sv
tb/sv/tb_float_format_converter_top.sv
